/* design/tdsd_pkg.sv */
`default_nettype none
package tdsd_pkg;

  localparam int ANIM_FRAMES_DEF = 14;
  localparam int SWEEP_LEN       = 14;
  localparam int Q_DEPTH         = 2;
  localparam int Q_AW            = 1;

  localparam logic [9:0] LIMIT_RST = 10'd310;
  localparam logic [9:0] MAX_SHOWN = 10'd999;
  localparam logic [7:0] DASH_RST  = 8'h02;

  localparam logic [1:0] DIG_NONE  = 2'd3;

  typedef enum logic [1:0] {
    REQ_SHOW = 2'd0,
    REQ_ON   = 2'd1,
    REQ_OFF  = 2'd2,
    REQ_SKIP = 2'd3
  } req_t;

  typedef logic [2:0][7:0] seg3_t;

  typedef struct packed {
    req_t  req;
    seg3_t tgt;
  } q_item_t;

  typedef struct packed {
    logic [1:0] sd;
    logic [1:0] ss;
    logic [1:0] cd;
    logic [1:0] cs;
  } sweep_op_t;

  function automatic logic [9:0] hund(input logic [3:0] h);
    logic [9:0] v;
    unique case (h)
      4'd1:    v = 10'd100;
      4'd2:    v = 10'd200;
      4'd3:    v = 10'd300;
      4'd4:    v = 10'd400;
      4'd5:    v = 10'd500;
      4'd6:    v = 10'd600;
      4'd7:    v = 10'd700;
      4'd8:    v = 10'd800;
      4'd9:    v = 10'd900;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] tens(input logic [3:0] t);
    logic [6:0] v;
    unique case (t)
      4'd1:    v = 7'd10;
      4'd2:    v = 7'd20;
      4'd3:    v = 7'd30;
      4'd4:    v = 7'd40;
      4'd5:    v = 7'd50;
      4'd6:    v = 7'd60;
      4'd7:    v = 7'd70;
      4'd8:    v = 7'd80;
      4'd9:    v = 7'd90;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  // segment byte, bits 0EDCBAGF
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] v;
    unique case (d)
      4'd0:    v = 8'h7D;
      4'd1:    v = 8'h18;
      4'd2:    v = 8'h6E;
      4'd3:    v = 8'h3E;
      4'd4:    v = 8'h1B;
      4'd5:    v = 8'h37;
      4'd6:    v = 8'h77;
      4'd7:    v = 8'h1C;
      4'd8:    v = 8'h7F;
      4'd9:    v = 8'h3F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] stage_mask(input logic [1:0] s);
    logic [7:0] v;
    unique case (s)
      2'd0:    v = 8'h41;
      2'd1:    v = 8'h26;
      2'd2:    v = 8'h18;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic sweep_op_t sweep_op(input logic [3:0] f);
    sweep_op_t v;
    unique case (f)
      4'd0:    v = '{DIG_NONE, 2'd0, DIG_NONE, 2'd0};
      4'd1:    v = '{2'd0,     2'd0, DIG_NONE, 2'd0};
      4'd2:    v = '{2'd0,     2'd1, DIG_NONE, 2'd0};
      4'd3:    v = '{2'd0,     2'd2, DIG_NONE, 2'd0};
      4'd4:    v = '{2'd1,     2'd0, DIG_NONE, 2'd0};
      4'd5:    v = '{2'd1,     2'd1, 2'd0,     2'd0};
      4'd6:    v = '{2'd1,     2'd2, 2'd0,     2'd1};
      4'd7:    v = '{2'd2,     2'd0, 2'd0,     2'd2};
      4'd8:    v = '{2'd2,     2'd1, 2'd1,     2'd0};
      4'd9:    v = '{2'd2,     2'd2, 2'd1,     2'd1};
      4'd10:   v = '{DIG_NONE, 2'd0, 2'd1,     2'd2};
      4'd11:   v = '{DIG_NONE, 2'd0, 2'd2,     2'd0};
      4'd12:   v = '{DIG_NONE, 2'd0, 2'd2,     2'd1};
      4'd13:   v = '{DIG_NONE, 2'd0, 2'd2,     2'd2};
      default: v = '{DIG_NONE, 2'd0, DIG_NONE, 2'd0};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/three_digit_segment_display_driver_top.sv */
`default_nettype none
// Three-digit seven-segment frame generator. Each pushed item carries a
// request (0 show, 1 animate on, 2 animate off, 3 ignored) and a 16-bit
// number; the number is split into hundreds, tens and ones with leading
// zeros blanked, or shown as the dash pattern on every digit when it exceeds
// the overflow limit (register 0, byte address 0, clamped to 999). Register
// 1 at byte address 4 holds the dash byte. Segment bytes are laid out
// 0EDCBAGF. A show request yields one frame; an animation yields ANIM_FRAMES
// frames of a left-to-right segment sweep, the final frame flagged by
// out_last. The back-end sequencer emits one frame per clock while the
// output frame is popped or empty; the front end splits digits in two
// pipelined stages and keeps up to two classified items queued ahead of the
// sequencer, and a pushed item passes the input stage register, the queue,
// the sequencer and the output register before its first frame appears.
module three_digit_segment_display_driver_top #(
  parameter int ANIM_FRAMES = tdsd_pkg::ANIM_FRAMES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_number,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_hundreds_segments,
  output logic [7:0]       out_tens_segments,
  output logic [7:0]       out_ones_segments,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tdsd_pkg::*;

  logic [9:0] limit_r;
  logic [7:0] dash_r;
  logic       cfg_wr;

  logic    q_ready, q_write, q_read, q_nempty;
  q_item_t wr_item, rd_item;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {24'd0, dash_r} : {22'd0, limit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      dash_r  <= DASH_RST;
    end else if (cfg_wr) begin
      if (paddr[2]) dash_r  <= pwdata[7:0];
      else          limit_r <= pwdata[9:0];
    end
  end

  tdsd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_number   (in_number),
    .limit       (limit_r),
    .dash        (dash_r),
    .q_ready     (q_ready),
    .q_write     (q_write),
    .q_item      (wr_item)
  );

  tdsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_write),
    .wr_item (wr_item),
    .ready   (q_ready),
    .rd      (q_read),
    .nempty  (q_nempty),
    .rd_item (rd_item)
  );

  tdsd_back #(
    .ANIM_FRAMES (ANIM_FRAMES)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_nempty              (q_nempty),
    .q_item                (rd_item),
    .q_read                (q_read),
    .empty                 (empty),
    .pop                   (pop),
    .out_hundreds_segments (out_hundreds_segments),
    .out_tens_segments     (out_tens_segments),
    .out_ones_segments     (out_ones_segments),
    .out_last              (out_last)
  );

endmodule
`default_nettype wire

/* design/tdsd_front.sv */
`default_nettype none
module tdsd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [15:0]       in_number,
  input  wire logic [9:0]        limit,
  input  wire logic [7:0]        dash,
  input  wire logic              q_ready,
  output logic                   q_write,
  output tdsd_pkg::q_item_t      q_item
);
  import tdsd_pkg::*;

  logic       a_vld_r, a_vld_nxt;
  req_t       a_req_r;
  logic       a_ovf_r;
  logic [3:0] a_h_r;
  logic [6:0] a_rem_r;

  logic       a_adv, a_load;
  logic [9:0] lim_eff, n10, rem10;
  logic [3:0] h, t;
  logic [6:0] o7;
  logic       blank_h, blank_t;

  assign a_adv   = q_ready || (a_req_r == REQ_SKIP);
  assign full    = a_vld_r && !a_adv;
  assign a_load  = push && !full;
  assign lim_eff = (limit > MAX_SHOWN) ? MAX_SHOWN : limit;
  assign n10     = in_number[9:0];

  // hundreds digit by threshold search, remainder below 100 for inputs up to 999
  always_comb begin
    h = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (n10 >= hund(4'(k))) h = 4'(k);
    end
    rem10 = n10 - hund(h);
  end

  assign a_vld_nxt = a_load || (a_vld_r && !a_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_req_r <= req_t'(in_req_type);
      a_ovf_r <= in_number > {6'd0, lim_eff};
      a_h_r   <= h;
      a_rem_r <= rem10[6:0];
    end
  end

  always_comb begin
    t = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (a_rem_r >= tens(4'(k))) t = 4'(k);
    end
    o7 = a_rem_r - tens(t);
  end

  assign blank_h = (a_h_r == 4'd0);
  assign blank_t = blank_h && (t == 4'd0);

  always_comb begin
    q_item.req = a_req_r;
    if (a_ovf_r) begin
      q_item.tgt = {dash, dash, dash};
    end else begin
      q_item.tgt[0] = blank_h ? 8'h00 : seg_of(a_h_r);
      q_item.tgt[1] = blank_t ? 8'h00 : seg_of(t);
      q_item.tgt[2] = seg_of(o7[3:0]);
    end
  end

  // drop unused request codes here
  assign q_write = a_vld_r && q_ready && (a_req_r != REQ_SKIP);

endmodule
`default_nettype wire

/* design/tdsd_queue.sv */
`default_nettype none
module tdsd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr,
  input  wire tdsd_pkg::q_item_t wr_item,
  output logic                   ready,
  input  wire logic              rd,
  output logic                   nempty,
  output tdsd_pkg::q_item_t      rd_item
);
  import tdsd_pkg::*;

  q_item_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign ready   = cnt_r != (Q_AW+1)'(Q_DEPTH);
  assign nempty  = cnt_r != '0;
  assign do_wr   = wr && ready;
  assign do_rd   = rd && nempty;
  assign rd_item = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + (Q_AW+1)'(do_wr) - (Q_AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

endmodule
`default_nettype wire

/* design/tdsd_back.sv */
`default_nettype none
module tdsd_back #(
  parameter int ANIM_FRAMES = tdsd_pkg::ANIM_FRAMES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_nempty,
  input  wire tdsd_pkg::q_item_t q_item,
  output logic                   q_read,
  output logic                   empty,
  input  wire logic              pop,
  output logic [7:0]             out_hundreds_segments,
  output logic [7:0]             out_tens_segments,
  output logic [7:0]             out_ones_segments,
  output logic                   out_last
);
  import tdsd_pkg::*;

  localparam int FW = (ANIM_FRAMES > 1) ? $clog2(ANIM_FRAMES) : 1;
  localparam int CW = (FW > 4) ? FW : 4;

  logic          busy_r, busy_nxt;
  logic          show_r;
  seg3_t         cur_r, keep_r;
  logic [FW-1:0] f_r;
  logic          out_vld_r, out_vld_nxt;
  seg3_t         out_seg_r;
  logic          out_last_r;

  logic          can_emit, emit, f_last, fin, load, in_sweep, is_on;
  logic [CW-1:0] f_ext;
  sweep_op_t     op;
  seg3_t         frame;

  assign f_ext    = CW'(f_r);
  assign in_sweep = f_ext < CW'(SWEEP_LEN);
  assign op       = sweep_op(f_ext[3:0]);
  assign f_last   = f_r == FW'(ANIM_FRAMES - 1);

  // one sweep step: clear a group on one digit, then light a group on another, either part optional
  always_comb begin
    frame = cur_r;
    if (!show_r && in_sweep) begin
      for (int i = 0; i < 3; i++) begin
        if (op.cd == 2'(i)) frame[i] = frame[i] & (~stage_mask(op.cs) | keep_r[i]);
        if (op.sd == 2'(i)) frame[i] = frame[i] | stage_mask(op.ss);
      end
    end
  end

  assign can_emit = !out_vld_r || pop;
  assign emit     = busy_r && can_emit;
  assign fin      = emit && (show_r || f_last);
  assign load     = q_nempty && (!busy_r || fin);
  assign q_read   = load;
  assign is_on    = q_item.req == REQ_ON;

  assign busy_nxt    = load || (busy_r && !fin);
  assign out_vld_nxt = emit || (out_vld_r && !pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      show_r <= q_item.req == REQ_SHOW;
      cur_r  <= is_on ? '0 : q_item.tgt;
      keep_r <= is_on ? q_item.tgt : '0;
      f_r    <= '0;
    end else if (emit) begin
      cur_r <= frame;
      f_r   <= f_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seg_r  <= frame;
      out_last_r <= show_r || f_last;
    end
  end

  assign empty                 = !out_vld_r;
  assign out_hundreds_segments = out_seg_r[0];
  assign out_tens_segments     = out_seg_r[1];
  assign out_ones_segments     = out_seg_r[2];
  assign out_last              = out_last_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int FRAMES_PER_ANIM = tdsd_pkg::ANIM_FRAMES_DEF;
  localparam int SWEEP_STEPS     = 14;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int LONG_HOLD       = 300;
  localparam int SETTLE_CYCLES   = 16;
  localparam int MAX_REPORTS     = 10;

  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_DASH  = 3'd4;

  localparam logic [1:0] NO_DIGIT = 2'd3;

  // segment bytes for 0..9, bits 0EDCBAGF
  localparam logic [0:9][7:0] DIGIT_SEGS = {
    8'h7D, 8'h18, 8'h6E, 8'h3E, 8'h1B, 8'h37, 8'h77, 8'h1C, 8'h7F, 8'h3F
  };

  // segment groups: E+F, D+A+G, C+B
  localparam logic [0:2][7:0] GROUP_SEGS = {8'h41, 8'h26, 8'h18};

  // per step: {digit to light, group to light, digit to clear, group to clear}
  localparam logic [0:SWEEP_STEPS-1][7:0] SWEEP = {
    {NO_DIGIT, 2'd0, NO_DIGIT, 2'd0}, {2'd0, 2'd0, NO_DIGIT, 2'd0},
    {2'd0, 2'd1, NO_DIGIT, 2'd0},     {2'd0, 2'd2, NO_DIGIT, 2'd0},
    {2'd1, 2'd0, NO_DIGIT, 2'd0},     {2'd1, 2'd1, 2'd0, 2'd0},
    {2'd1, 2'd2, 2'd0, 2'd1},         {2'd2, 2'd0, 2'd0, 2'd2},
    {2'd2, 2'd1, 2'd1, 2'd0},         {2'd2, 2'd2, 2'd1, 2'd1},
    {NO_DIGIT, 2'd0, 2'd1, 2'd2},     {NO_DIGIT, 2'd0, 2'd2, 2'd0},
    {NO_DIGIT, 2'd0, 2'd2, 2'd1},     {NO_DIGIT, 2'd0, 2'd2, 2'd2}
  };

  typedef struct packed {
    tdsd_pkg::req_t req;
    logic [15:0]    number;
  } request_t;

  typedef struct packed {
    logic [7:0] seg_h;
    logic [7:0] seg_t;
    logic [7:0] seg_o;
    logic       last;
  } frame_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_number = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_hundreds_segments;
  logic [7:0]  out_tens_segments;
  logic [7:0]  out_ones_segments;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  request_t    requests_pending[$];
  frame_t      frames_due[$];

  logic [9:0]  limit_reg = tdsd_pkg::LIMIT_RST;
  logic [7:0]  dash_reg = tdsd_pkg::DASH_RST;

  int          mismatches = 0;
  int          cycles = 0;
  bit          in_taken = 1'b0;
  bit          quiet = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          holds_asked = 0;
  int          holds_done = 0;

  three_digit_segment_display_driver_top #(
    .ANIM_FRAMES(FRAMES_PER_ANIM)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .push                  (push),
    .full                  (full),
    .in_req_type           (in_req_type),
    .in_number             (in_number),
    .empty                 (empty),
    .pop                   (pop),
    .out_hundreds_segments (out_hundreds_segments),
    .out_tens_segments     (out_tens_segments),
    .out_ones_segments     (out_ones_segments),
    .out_last              (out_last),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // none half the time, otherwise mostly short, a few long
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic predict_frames(input tdsd_pkg::req_t req, input logic [15:0] num);
    logic [7:0] tgt[3];
    logic [7:0] keep[3];
    logic [7:0] cur[3];
    logic [9:0] lim;
    logic [7:0] op;
    int         h, t, o, f, d;
    frame_t     fr;
    lim = (limit_reg > 10'd999) ? 10'd999 : limit_reg;
    if (num > lim) begin
      for (d = 0; d < 3; d++) tgt[d] = dash_reg;
    end else begin
      h = num / 100;
      t = (num / 10) % 10;
      o = num % 10;
      tgt[0] = (h == 0) ? 8'h00 : DIGIT_SEGS[h];
      tgt[1] = (h == 0 && t == 0) ? 8'h00 : DIGIT_SEGS[t];
      tgt[2] = DIGIT_SEGS[o];
    end
    if (req == tdsd_pkg::REQ_SHOW) begin
      fr = '{tgt[0], tgt[1], tgt[2], 1'b1};
      frames_due.push_back(fr);
    end else if (req != tdsd_pkg::REQ_SKIP) begin
      for (d = 0; d < 3; d++) begin
        cur[d]  = (req == tdsd_pkg::REQ_ON) ? 8'h00 : tgt[d];
        keep[d] = (req == tdsd_pkg::REQ_ON) ? tgt[d] : 8'h00;
      end
      for (f = 0; f < FRAMES_PER_ANIM; f++) begin
        // past the sweep, repeat its final frame
        if (f < SWEEP_STEPS) begin
          op = SWEEP[f];
          if (op[3:2] != NO_DIGIT)
            cur[op[3:2]] &= ~GROUP_SEGS[op[1:0]] | keep[op[3:2]];
          if (op[7:6] != NO_DIGIT)
            cur[op[7:6]] |= GROUP_SEGS[op[5:4]];
        end
        fr = '{cur[0], cur[1], cur[2], f == FRAMES_PER_ANIM - 1};
        frames_due.push_back(fr);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input frame_t want, input frame_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected h=%h t=%h o=%h last=%b, got h=%h t=%h o=%h last=%b",
               $time, what, want.seg_h, want.seg_t, want.seg_o, want.last,
               got.seg_h, got.seg_t, got.seg_o, got.last);
  endtask

  // accept input beats into the predictor, check output beats
  always @(posedge clk) begin
    frame_t got;
    frame_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (push && !full) begin
        in_taken = 1'b1;
        predict_frames(tdsd_pkg::req_t'(in_req_type), in_number);
      end
      if (pop && !empty) begin
        got = '{out_hundreds_segments, out_tens_segments, out_ones_segments, out_last};
        if (frames_due.size() == 0) begin
          note_mismatch("frame with nothing due", '0, got);
        end else begin
          want = frames_due.pop_front();
          if (got !== want) note_mismatch("frame mismatch", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin
    request_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || in_taken) begin
      if (send_gap != 0) begin
        push <= 1'b0;
        send_gap--;
      end else if (requests_pending.size() != 0) begin
        nxt = requests_pending.pop_front();
        push <= 1'b1;
        in_req_type <= nxt.req;
        in_number <= nxt.number;
        send_gap = quiet ? 0 : pick_gap();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      // hold off long enough for the block to back up into its input
      holds_done++;
      hold_left = LONG_HOLD;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (!quiet && $urandom_range(5) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_request(input tdsd_pkg::req_t req, input logic [15:0] num);
    request_t r;
    r.req = req;
    r.number = num;
    requests_pending.push_back(r);
  endtask

  task automatic add_random(input int count);
    int unsigned pick;
    logic [9:0]  lim;
    logic [15:0] num;
    tdsd_pkg::req_t req;
    lim = (limit_reg > 10'd999) ? 10'd999 : limit_reg;
    repeat (count) begin
      pick = $urandom_range(15);
      if (pick == 0) req = tdsd_pkg::REQ_SKIP;
      else if (pick < 6) req = tdsd_pkg::REQ_SHOW;
      else if (pick < 11) req = tdsd_pkg::REQ_ON;
      else req = tdsd_pkg::REQ_OFF;
      case ($urandom_range(3))
        0: num = 16'($urandom);
        1: num = 16'({6'd0, lim} + $urandom_range(2) - 16'd1);
        default: num = 16'($urandom_range(999));
      endcase
      add_request(req, num);
    end
  endtask

  // let everything drain, including requests that make no frames
  task automatic wait_idle();
    while (requests_pending.size() != 0 || push || frames_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LIMIT) limit_reg = value[9:0];
    else dash_reg = value[7:0];
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: blanking, limit edges, overflow, ignored requests
    add_request(tdsd_pkg::REQ_SHOW, 16'd0);
    add_request(tdsd_pkg::REQ_SHOW, 16'd9);
    add_request(tdsd_pkg::REQ_SHOW, 16'd10);
    add_request(tdsd_pkg::REQ_SHOW, 16'd100);
    add_request(tdsd_pkg::REQ_SHOW, 16'd105);
    add_request(tdsd_pkg::REQ_SHOW, 16'd310);
    add_request(tdsd_pkg::REQ_SHOW, 16'd311);
    add_request(tdsd_pkg::REQ_SHOW, 16'hFFFF);
    add_request(tdsd_pkg::REQ_ON, 16'd0);
    add_request(tdsd_pkg::REQ_ON, 16'd308);
    add_request(tdsd_pkg::REQ_OFF, 16'd208);
    add_request(tdsd_pkg::REQ_OFF, 16'd311);
    add_request(tdsd_pkg::REQ_SKIP, 16'd123);
    add_request(tdsd_pkg::REQ_SKIP, 16'hFFFF);
    wait_idle();

    // limit beyond the digit range, dash with bit 7 set
    write_reg(ADDR_LIMIT, 32'd1023);
    write_reg(ADDR_DASH, 32'h0000_00FF);
    add_request(tdsd_pkg::REQ_SHOW, 16'd999);
    add_request(tdsd_pkg::REQ_ON, 16'd999);
    add_request(tdsd_pkg::REQ_SHOW, 16'd1000);
    add_request(tdsd_pkg::REQ_OFF, 16'd1000);
    add_request(tdsd_pkg::REQ_ON, 16'd1000);
    holds_asked++;
    add_random(40);
    wait_idle();

    write_reg(ADDR_LIMIT, 32'd0);
    write_reg(ADDR_DASH, 32'h0000_0000);
    add_request(tdsd_pkg::REQ_SHOW, 16'd0);
    add_request(tdsd_pkg::REQ_SHOW, 16'd1);
    add_request(tdsd_pkg::REQ_ON, 16'h8000);
    add_random(40);
    wait_idle();

    write_reg(ADDR_LIMIT, 32'd999);
    write_reg(ADDR_DASH, 32'h0000_0080);
    add_request(tdsd_pkg::REQ_OFF, 16'hFFFF);
    add_request(tdsd_pkg::REQ_SHOW, 16'd999);
    add_request(tdsd_pkg::REQ_SHOW, 16'd1000);
    quiet = 1'b1;
    add_random(40);
    wait_idle();
    quiet = 1'b0;

    write_reg(ADDR_LIMIT, $urandom_range(1023));
    write_reg(ADDR_DASH, $urandom_range(255));
    holds_asked++;
    add_random(40);
    wait_idle();

    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
design/tdsd_pkg.sv
design/tdsd_front.sv
design/tdsd_queue.sv
design/tdsd_back.sv
design/three_digit_segment_display_driver_top.sv
tb/tb_top.sv
